### rtl/psts_pkg.sv
package psts_pkg;

  // command codes carried in the low bits of in_tdata
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_DONE  = 2'd3;

  localparam int CMD_W       = 2;
  localparam int SLOT_W      = 3;
  localparam int PERIOD_W    = 32;
  localparam int SLOT_SPAN   = 8;   // slot indexes a command can address
  localparam int MAX_REPORT  = 8;   // results reported per tick at most
  localparam int REPORT_W    = 4;   // holds 0 .. MAX_REPORT
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // one slot command, decoded once and broadcast to every cell
  typedef struct packed {
    logic                wr_set;
    logic                wr_clear;
    logic                wr_done;
    logic                keep;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } slot_cmd_t;

endpackage

### rtl/psts_cell.sv
module psts_cell
  import psts_pkg::*;
#(
  parameter int TICK_BITS = 32,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slot_cmd_t            cmd_i,
  input  logic [TICK_BITS-1:0] now_i,
  input  logic                 adv_i,
  input  logic                 tok_v_i,
  input  logic [TICK_BITS-1:0] tok_tick_i,
  output logic                 tok_v_o,
  output logic [TICK_BITS-1:0] tok_tick_o,
  output logic                 hit_o
);

  localparam int SUM_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;
  localparam logic [SLOT_W-1:0] IDX_CODE = SLOT_W'(CELL_IDX % SLOT_SPAN);
  localparam logic ADDRESSABLE = (CELL_IDX < SLOT_SPAN);

  logic                 en_r;
  logic [PERIOD_W-1:0]  per_r;
  logic [TICK_BITS-1:0] dl_r;
  logic                 tok_v_r;
  logic [TICK_BITS-1:0] tok_tick_r;

  logic                 sel;
  logic [SUM_W-1:0]     set_sum;
  logic [SUM_W-1:0]     scan_sum;

  assign sel      = ADDRESSABLE && (cmd_i.slot == IDX_CODE);
  assign set_sum  = SUM_W'(cmd_i.period) + SUM_W'(now_i);
  assign scan_sum = SUM_W'(per_r) + SUM_W'(tok_tick_r);
  assign hit_o    = tok_v_r && en_r && (dl_r <= tok_tick_r);

  assign tok_v_o    = tok_v_r;
  assign tok_tick_o = tok_tick_r;

  // token moves one cell down the chain whenever the scan advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r    <= 1'b0;
      tok_tick_r <= '0;
    end else if (adv_i) begin
      tok_v_r    <= tok_v_i;
      tok_tick_r <= tok_tick_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      per_r <= '0;
      dl_r  <= '0;
    end else begin
      if (sel && cmd_i.wr_set) begin
        en_r  <= 1'b1;
        per_r <= cmd_i.period;
        dl_r  <= set_sum[TICK_BITS-1:0];
      end else if (sel && cmd_i.wr_clear) begin
        en_r <= 1'b0;
      end else if (sel && cmd_i.wr_done) begin
        en_r <= cmd_i.keep;
      end else if (adv_i && hit_o) begin
        dl_r <= scan_sum[TICK_BITS-1:0];
      end
    end
  end

endmodule

### rtl/periodic_slot_timer_scheduler.sv
// channel | dir | tdata (low bit up)                           | side bits
// in_     | in  | cmd[1:0] slot[4:2] period[36:5] keep[37] pad  | -
// out_    | out | due_slot[2:0] pad                             | tlast = last
//
// a tick launches the scan token, then the token walks the chain through
// every slot cell, then the held result is flushed with last set. set, clear
// and done are applied to the addressed slot cell without a scan.
// in_tready is low for the whole scan; the chain freezes while a result waits
// in the output register and out_tready is low. reset clears all slots and
// the tick counter.
module periodic_slot_timer_scheduler
  import psts_pkg::*;
#(
  parameter int SLOTS     = 8,
  parameter int TICK_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cmd, slot, period, keep_enabled
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // due_slot
  output logic                   out_tlast
);

  // input field unpacking
  logic [CMD_W-1:0]    in_cmd;
  logic [SLOT_W-1:0]   in_slot;
  logic [PERIOD_W-1:0] in_period;
  logic                in_keep;

  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_slot   = in_tdata[CMD_W+SLOT_W-1:CMD_W];
  assign in_period = in_tdata[CMD_W+SLOT_W+PERIOD_W-1:CMD_W+SLOT_W];
  assign in_keep   = in_tdata[CMD_W+SLOT_W+PERIOD_W];

  // control state
  logic                 busy_r;      // a tick scan is in flight
  logic                 launch_r;    // token waiting to enter cell 0
  logic                 tail_r;      // token has left the last cell
  logic [TICK_BITS-1:0] tick_now_r;
  logic                 pend_v_r;    // one due slot held back until we know if it is last
  logic [SLOT_W-1:0]    pend_idx_r;
  logic [REPORT_W-1:0]  cnt_r;       // results reported on this tick
  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_last_r;

  logic      in_fire;
  logic      tick_fire;
  logic      adv;
  slot_cmd_t cmd;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign tick_fire = in_fire && (in_cmd == CMD_TICK);
  // scan steps only when the output register can take a result
  assign adv       = !out_valid_r || out_tready;

  always_comb begin
    cmd.wr_set   = in_fire && (in_cmd == CMD_SET);
    cmd.wr_clear = in_fire && (in_cmd == CMD_CLEAR);
    cmd.wr_done  = in_fire && (in_cmd == CMD_DONE);
    cmd.keep     = in_keep;
    cmd.slot     = in_slot;
    cmd.period   = in_period;
  end

  // cell chain: token carries the fresh tick value from cell to cell
  logic                 tok_v    [SLOTS+1];
  logic [TICK_BITS-1:0] tok_tick [SLOTS+1];
  logic [SLOTS-1:0]     hit;

  assign tok_v[0]    = launch_r;
  assign tok_tick[0] = tick_now_r;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    psts_cell #(
      .TICK_BITS (TICK_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd),
      .now_i      (tick_now_r),
      .adv_i      (adv),
      .tok_v_i    (tok_v[k]),
      .tok_tick_i (tok_tick[k]),
      .tok_v_o    (tok_v[k+1]),
      .tok_tick_o (tok_tick[k+1]),
      .hit_o      (hit[k])
    );
  end

  // at most one cell holds the token, so hit is one-hot or empty
  logic              hit_any;
  logic [SLOT_W-1:0] hit_idx;

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (hit[k]) hit_idx = hit_idx | SLOT_W'(k);
    end
  end
  assign hit_any = |hit;

  // result collection: a new report pushes the held one out with last clear,
  // the end of the scan pushes the held one with last set
  logic report;
  logic push;
  logic push_last;

  assign report    = adv && hit_any && (cnt_r < REPORT_W'(MAX_REPORT));
  assign push      = (report && pend_v_r) || (adv && tail_r && pend_v_r);
  assign push_last = adv && tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      launch_r   <= 1'b0;
      tail_r     <= 1'b0;
      tick_now_r <= '0;
      pend_v_r   <= 1'b0;
      pend_idx_r <= '0;
      cnt_r      <= '0;
    end else begin
      if (tick_fire) begin
        busy_r     <= 1'b1;
        launch_r   <= 1'b1;
        tick_now_r <= tick_now_r + TICK_BITS'(1);
      end else if (adv) begin
        launch_r <= 1'b0;
      end
      if (adv) tail_r <= tok_v[SLOTS];
      if (adv && tail_r) begin
        busy_r   <= 1'b0;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end else if (report) begin
        pend_v_r   <= 1'b1;
        pend_idx_r <= hit_idx;
        cnt_r      <= cnt_r + REPORT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_slot_r  <= '0;
      out_last_r  <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
      out_slot_r  <= pend_idx_r;
      out_last_r  <= push_last;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SLOT_W){1'b0}}, out_slot_r};
  assign out_tlast  = out_last_r;

endmodule
